// ----- hdl/mbca_pkg.sv -----
// Shared types, codes and constants of the memory bank conflict arbiter.
// Used by the front, back, top level and checker; depends on nothing.
package mbca_pkg;

  localparam int DEF_MAX_PROCS  = 64;
  localparam int DEF_MAX_BANKS  = 2048;
  localparam int DEF_COUNT_BITS = 24;

  localparam int OP_W     = 2;
  localparam int BANK_IN_W = 11;
  localparam int PROC_CFG_W = 7;
  localparam int MEM_CFG_W  = 12;
  localparam int PID_OUT_W  = 6;
  localparam int TOTAL_W    = 24;

  localparam logic [PROC_CFG_W-1:0] PROC_COUNT_RST = 7'd64;
  localparam logic [MEM_CFG_W-1:0]  MEM_COUNT_RST  = 12'd2048;

  localparam logic [0:0] CFG_PROC_COUNT = 1'b0;
  localparam logic [0:0] CFG_MEM_COUNT  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_REQ = 2'd0,
    OP_EOR = 2'd1,
    OP_CLR = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  kind;
    logic [BANK_IN_W-1:0] bank;
    logic                 bank_ok;
  } cmd_t;

  typedef struct packed {
    logic [PID_OUT_W-1:0] proc_id;
    logic                 granted;
    logic [TOTAL_W-1:0]   wait_total;
    logic [TOTAL_W-1:0]   grant_total;
    status_t              status;
    logic                 round_done;
  } res_t;

endpackage

// ----- hdl/mbca_front.sv -----
// Front end: accepts input beats, classifies them into commands and queues
// them for the back end. Depends on mbca_pkg.
module mbca_front
  import mbca_pkg::*;
#(
  parameter int MAX_BANKS = DEF_MAX_BANKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [OP_W-1:0]      in_tuser,  // op
  input  logic [15:0]          in_tdata,  // bank_index[10:0], zero fill
  input  logic [MEM_CFG_W-1:0] mem_count,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cmd_in;
  logic [31:0] eff_banks;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign eff_banks = (32'(mem_count) < MAX_BANKS) ? 32'(mem_count) : 32'(MAX_BANKS);

  always_comb begin
    cmd_in.kind    = op_t'(in_tuser);
    cmd_in.bank    = in_tdata[BANK_IN_W-1:0];
    cmd_in.bank_ok = (32'(in_tdata[BANK_IN_W-1:0]) < eff_banks);
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (cmd_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ----- hdl/mbca_back.sv -----
// Back end: runs requests, the end-of-round reorder pass and statistics clear
// against the priority, counter and bank busy memories. Depends on mbca_pkg.
module mbca_back
  import mbca_pkg::*;
#(
  parameter int MAX_PROCS  = DEF_MAX_PROCS,
  parameter int MAX_BANKS  = DEF_MAX_BANKS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PROC_CFG_W-1:0] proc_count,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  res_valid,
  output res_t                  res,
  input  logic                  res_take
);

  localparam int SLOT_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SP_W    = $clog2(MAX_PROCS + 1);
  localparam int BANK_W  = ($clog2(MAX_BANKS) > 2) ? $clog2(MAX_BANKS) : 2;
  localparam int ROW_AW  = (BANK_W - 1 < 6) ? BANK_W - 1 : 6;
  localparam int BIT_W   = BANK_W - ROW_AW;
  localparam int ROWS    = 2 ** ROW_AW;
  localparam int WORD_W  = 2 ** BIT_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_REQ_RD  = 8'b0000_0010,
    S_REQ_CNT = 8'b0000_0100,
    S_REQ_UPD = 8'b0000_1000,
    S_RO_TEST = 8'b0001_0000,
    S_RO_SW1  = 8'b0010_0000,
    S_RO_SW2  = 8'b0100_0000,
    S_RO_SCAN = 8'b1000_0000
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // memories
  logic [SLOT_W-1:0]     ord_mem   [MAX_PROCS];
  logic [COUNT_BITS-1:0] wait_mem  [MAX_PROCS];
  logic [COUNT_BITS-1:0] grant_mem [MAX_PROCS];
  logic [WORD_W-1:0]     busy_mem  [ROWS];

  logic [SLOT_W-1:0]     ord_rda_r, ord_rdb_r;
  logic [COUNT_BITS-1:0] wait_rd_r, grant_rd_r;
  logic [WORD_W-1:0]     busy_rd_r;

  logic [SLOT_W-1:0]     ord_raa, ord_rab, ord_wa, ord_wd, cnt_ra;
  logic                  ord_we, cnt_we, busy_we;
  logic [COUNT_BITS-1:0] wait_wd, grant_wd;
  logic [WORD_W-1:0]     busy_wd;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [SP_W-1:0]       slot_r, slot_nxt, p_r, p_nxt, front_r, front_nxt, q_r, q_nxt;
  logic [SLOT_W-1:0]     pid_r, pid_nxt, tmp_r, tmp_nxt;
  logic [MAX_PROCS-1:0]  ord_vld_r, ord_vld_nxt, cnt_vld_r, cnt_vld_nxt;
  logic [MAX_PROCS-1:0]  asg_r, asg_nxt;
  logic [ROWS-1:0]       row_vld_r, row_vld_nxt;
  res_t                  res_r, res_nxt;
  logic                  res_vld_r, res_vld_nxt;

  logic [SP_W-1:0]       eff_procs;
  logic [BANK_W-1:0]     bidx;
  logic [ROW_AW-1:0]     row;
  logic [BIT_W-1:0]      bit_sel;
  logic [SLOT_W-1:0]     slot_i, p_i, f_i, q_i, ord_a, ord_b;
  logic [COUNT_BITS-1:0] cw, cg, cw_inc, cg_inc;
  logic [WORD_W-1:0]     busy_word;
  logic                  asg_p, asg_f;

  assign eff_procs = (32'(proc_count) < MAX_PROCS) ? SP_W'(proc_count) : SP_W'(MAX_PROCS);
  assign bidx      = BANK_W'(cmd_r.bank);
  assign row       = bidx[BANK_W-1:BIT_W];
  assign bit_sel   = bidx[BIT_W-1:0];
  assign slot_i    = slot_r[SLOT_W-1:0];
  assign p_i       = p_r[SLOT_W-1:0];
  assign f_i       = front_r[SLOT_W-1:0];
  assign q_i       = q_r[SLOT_W-1:0];
  assign cw        = cnt_vld_r[pid_r] ? wait_rd_r  : '0;
  assign cg        = cnt_vld_r[pid_r] ? grant_rd_r : '0;
  assign cw_inc    = sat_inc(cw);
  assign cg_inc    = sat_inc(cg);
  assign busy_word = row_vld_r[row] ? busy_rd_r : '0;
  assign res_valid = res_vld_r;
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    slot_nxt    = slot_r;
    p_nxt       = p_r;
    front_nxt   = front_r;
    q_nxt       = q_r;
    pid_nxt     = pid_r;
    tmp_nxt     = tmp_r;
    ord_vld_nxt = ord_vld_r;
    cnt_vld_nxt = cnt_vld_r;
    asg_nxt     = asg_r;
    row_vld_nxt = row_vld_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !res_take;
    cmd_pop     = 1'b0;
    ord_raa     = slot_i;
    ord_rab     = f_i;
    ord_we      = 1'b0;
    ord_wa      = p_i;
    ord_wd      = '0;
    cnt_ra      = pid_r;
    cnt_we      = 1'b0;
    wait_wd     = cw;
    grant_wd    = cg;
    busy_we     = 1'b0;
    busy_wd     = busy_word;
    ord_a       = ord_vld_r[p_i] ? ord_rda_r : p_i;
    ord_b       = ord_vld_r[f_i] ? ord_rdb_r : f_i;
    asg_p       = asg_r[p_i];
    asg_f       = asg_r[f_i];

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_vld_r) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          res_nxt = '0;
          case (cmd.kind)
            OP_REQ: state_nxt = S_REQ_RD;
            OP_EOR: begin
              p_nxt     = '0;
              front_nxt = '0;
              state_nxt = S_RO_TEST;
            end
            OP_CLR: begin
              cnt_vld_nxt        = '0;
              res_nxt.round_done = 1'b1;
              res_vld_nxt        = 1'b1;
            end
            default: res_vld_nxt = 1'b1;
          endcase
        end
      end
      S_REQ_RD: begin
        if (slot_r >= eff_procs) begin
          res_nxt.status = ST_FULL;
          res_vld_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_REQ_CNT;
        end
      end
      S_REQ_CNT: begin
        pid_nxt   = ord_vld_r[slot_i] ? ord_rda_r : slot_i;
        cnt_ra    = pid_nxt;
        state_nxt = S_REQ_UPD;
      end
      S_REQ_UPD: begin
        res_nxt.proc_id = PID_OUT_W'(pid_r);
        if (!cmd_r.bank_ok) begin
          res_nxt.status      = ST_RANGE;
          res_nxt.wait_total  = TOTAL_W'(cw);
          res_nxt.grant_total = TOTAL_W'(cg);
        end else begin
          cnt_we             = 1'b1;
          cnt_vld_nxt[pid_r] = 1'b1;
          slot_nxt           = slot_r + 1'b1;
          if (busy_word[bit_sel]) begin
            wait_wd             = cw_inc;
            res_nxt.wait_total  = TOTAL_W'(cw_inc);
            res_nxt.grant_total = TOTAL_W'(cg);
          end else begin
            grant_wd              = cg_inc;
            res_nxt.granted       = 1'b1;
            res_nxt.wait_total    = TOTAL_W'(cw);
            res_nxt.grant_total   = TOTAL_W'(cg_inc);
            asg_nxt[slot_i]       = 1'b1;
            busy_we               = 1'b1;
            busy_wd[bit_sel]      = 1'b1;
            row_vld_nxt[row]      = 1'b1;
          end
        end
        res_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RO_TEST: begin
        ord_raa = p_i;
        if (p_r >= eff_procs) begin
          asg_nxt            = '0;
          row_vld_nxt        = '0;
          slot_nxt           = '0;
          res_nxt.round_done = 1'b1;
          res_vld_nxt        = 1'b1;
          state_nxt          = S_IDLE;
        end else if (!asg_r[p_i] && front_r < eff_procs) begin
          state_nxt = S_RO_SW1;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_RO_SW1: begin
        // move the front entry into slot p, hold the old slot p entry
        ord_we           = 1'b1;
        ord_wa           = p_i;
        ord_wd           = ord_b;
        ord_vld_nxt[p_i] = 1'b1;
        tmp_nxt          = ord_a;
        asg_nxt[p_i]     = asg_f;
        asg_nxt[f_i]     = asg_p;
        state_nxt        = S_RO_SW2;
      end
      S_RO_SW2: begin
        ord_we           = 1'b1;
        ord_wa           = f_i;
        ord_wd           = tmp_r;
        ord_vld_nxt[f_i] = 1'b1;
        q_nxt            = front_r + 1'b1;
        state_nxt        = S_RO_SCAN;
      end
      S_RO_SCAN: begin
        if (q_r < eff_procs && !asg_r[q_i]) begin
          q_nxt = q_r + 1'b1;
        end else begin
          front_nxt = q_r;
          p_nxt     = p_r + 1'b1;
          state_nxt = S_RO_TEST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rda_r <= ord_mem[ord_raa];
    ord_rdb_r <= ord_mem[ord_rab];
    if (cnt_we) begin
      wait_mem[pid_r]  <= wait_wd;
      grant_mem[pid_r] <= grant_wd;
    end
    wait_rd_r  <= wait_mem[cnt_ra];
    grant_rd_r <= grant_mem[cnt_ra];
    if (busy_we) begin
      busy_mem[row] <= busy_wd;
    end
    busy_rd_r <= busy_mem[row];
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    p_r     <= p_nxt;
    front_r <= front_nxt;
    q_r     <= q_nxt;
    pid_r   <= pid_nxt;
    tmp_r   <= tmp_nxt;
    res_r   <= res_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      slot_r    <= '0;
      ord_vld_r <= '0;
      cnt_vld_r <= '0;
      asg_r     <= '0;
      row_vld_r <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      ord_vld_r <= ord_vld_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      asg_r     <= asg_nxt;
      row_vld_r <= row_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

endmodule

// ----- hdl/memory_bank_conflict_arbiter.sv -----
// Top level of the memory bank conflict arbiter: configuration registers,
// front end, back end and result packing. Depends on mbca_pkg, mbca_front, mbca_back.
//
//  channel | direction | tvalid/tready  | tuser          | tdata
//  in_     | slave     | in_tvalid      | op             | bank_index
//  out_    | master    | out_tvalid     | status, done   | proc_id .. grant_total
//  cfg_    | write     | cfg_we         | -              | cfg_addr, cfg_wdata
//
// A request passes through S_REQ_RD, S_REQ_CNT and S_REQ_UPD in the back end and
// then the output register; end of round walks the priority order with the swap
// sequencer: S_RO_TEST per slot, and S_RO_SW1, S_RO_SW2 and S_RO_SCAN per swapped
// slot, the scan skipping unserved slots; S_RO_TEST finishes. Clear is done in S_IDLE.
// Reset is synchronous; flag vectors make all state read as reset at once.
// The two-entry command queue keeps accepting, until full, while a result waits on out_tready.
module memory_bank_conflict_arbiter
  import mbca_pkg::*;
#(
  parameter int MAX_PROCS  = DEF_MAX_PROCS,
  parameter int MAX_BANKS  = DEF_MAX_BANKS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [OP_W-1:0]      in_tuser,   // op
  input  logic [15:0]          in_tdata,   // bank_index[10:0], zero fill
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,  // proc_id, granted, wait_total, grant_total
  output logic [2:0]           out_tuser,  // status, round_done
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_addr,
  input  logic [MEM_CFG_W-1:0] cfg_wdata
);

  logic [PROC_CFG_W-1:0] proc_count_r;
  logic [MEM_CFG_W-1:0]  mem_count_r;
  logic                  cmd_valid, cmd_pop;
  cmd_t                  cmd;
  res_t                  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= PROC_COUNT_RST;
      mem_count_r  <= MEM_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PROC_COUNT: proc_count_r <= cfg_wdata[PROC_CFG_W-1:0];
        CFG_MEM_COUNT:  mem_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mbca_front #(.MAX_BANKS(MAX_BANKS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .mem_count(mem_count_r), .cmd_valid, .cmd, .cmd_pop
  );

  mbca_back #(.MAX_PROCS(MAX_PROCS), .MAX_BANKS(MAX_BANKS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .proc_count(proc_count_r), .cmd_valid, .cmd, .cmd_pop,
    .res_valid(out_tvalid), .res, .res_take(out_tready)
  );

  assign out_tdata = {1'b0, res.grant_total, res.wait_total, res.granted, res.proc_id};
  assign out_tuser = {res.round_done, res.status};

endmodule

// ----- hdl/mbca_checker.sv -----
// Port-level checks of the memory bank conflict arbiter, bound to the top level.
// Depends on mbca_pkg and memory_bank_conflict_arbiter.
module mbca_checker
  import mbca_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 56'd0 && out_tuser[1:0] == ST_OK)
    else $error("round acknowledgement carries data");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_FULL |-> out_tdata == 56'd0 && !out_tuser[2])
    else $error("full round result carries data");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tuser[1:0] == ST_OK && out_tdata[54:31] != 24'd0)
    else $error("grant with bad status or zero grant count");

endmodule

bind memory_bank_conflict_arbiter mbca_checker u_mbca_checker (.*);

// ----- verif/memory_bank_conflict_arbiter_tb.sv -----
// Testbench of the memory bank conflict arbiter: directed and random beats,
// self-checking against an arbitration predictor. Depends on mbca_pkg and the RTL.
`timescale 1ns / 1ps
module memory_bank_conflict_arbiter_tb
  import mbca_pkg::*;
();

  localparam int NPROC = 64;
  localparam int NBANK = 2048;
  localparam logic [23:0] CNT_SAT = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [OP_W-1:0] in_tuser;
  logic [15:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_we;
  logic [0:0] cfg_addr;
  logic [MEM_CFG_W-1:0] cfg_wdata;

  memory_bank_conflict_arbiter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    op_t kind;
    logic [10:0] bank;
  } beat_t;

  // predictor state
  logic [6:0] proc_cnt;
  logic [11:0] mem_cnt;
  logic [5:0] prio[NPROC];
  logic assigned[NPROC];
  logic busy[NBANK];
  logic [23:0] waits[NPROC];
  logic [23:0] grants[NPROC];
  int slot_ptr;

  beat_t pending_beats[$];
  res_t expected_results[$];
  int fail_count;
  int send_idle_pct, recv_stall_pct;
  longint cycle_count;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int procs_in_use();
    return (proc_cnt < NPROC) ? proc_cnt : NPROC;
  endfunction

  function automatic int banks_in_use();
    return (mem_cnt < NBANK) ? mem_cnt : NBANK;
  endfunction

  function automatic int next_served(int from, int n);
    int q;
    q = from + 1;
    while (q < n && !assigned[prio[q]]) q++;
    return q;
  endfunction

  function automatic void arbiter_reset();
    proc_cnt = PROC_COUNT_RST;
    mem_cnt = MEM_COUNT_RST;
    for (int i = 0; i < NPROC; i++) begin
      prio[i] = i[5:0]; assigned[i] = 0; waits[i] = 0; grants[i] = 0;
    end
    for (int i = 0; i < NBANK; i++) busy[i] = 0;
    slot_ptr = 0;
  endfunction

  function automatic res_t arbitrate(beat_t b);
    res_t r;
    int n, front;
    logic [5:0] pid, t;
    r = '0;
    r.status = ST_OK;
    case (b.kind)
      OP_REQ: begin
        if (slot_ptr >= procs_in_use()) begin
          r.status = ST_FULL;
        end else begin
          pid = prio[slot_ptr];
          r.proc_id = pid;
          if (b.bank >= banks_in_use()) begin
            r.status = ST_RANGE;
          end else begin
            if (busy[b.bank]) begin
              if (waits[pid] != CNT_SAT) waits[pid]++;
            end else begin
              if (grants[pid] != CNT_SAT) grants[pid]++;
              assigned[pid] = 1; busy[b.bank] = 1; r.granted = 1;
            end
            slot_ptr++;
          end
          r.wait_total = waits[pid];
          r.grant_total = grants[pid];
        end
      end
      OP_EOR: begin
        n = procs_in_use();
        front = 0;
        for (int p = 0; p < n; p++) begin
          if (!assigned[prio[p]] && front < n) begin
            t = prio[p]; prio[p] = prio[front]; prio[front] = t;
            front = next_served(front, n);
          end
        end
        for (int i = 0; i < NPROC; i++) assigned[i] = 0;
        for (int i = 0; i < NBANK; i++) busy[i] = 0;
        slot_ptr = 0;
        r.round_done = 1;
      end
      OP_CLR: begin
        for (int i = 0; i < NPROC; i++) begin
          waits[i] = 0; grants[i] = 0;
        end
        r.round_done = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1;
        in_tuser <= pending_beats[0].kind;
        in_tdata <= {5'b0, pending_beats[0].bank};
        expected_results.push_back(arbitrate(pending_beats.pop_front()));
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got.proc_id = out_tdata[5:0];
        got.granted = out_tdata[6];
        got.wait_total = out_tdata[30:7];
        got.grant_total = out_tdata[54:31];
        got.status = status_t'(out_tuser[1:0]);
        got.round_done = out_tuser[2];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic queue_beat(op_t k, int bank);
    beat_t b;
    b.kind = k; b.bank = bank[10:0];
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val[11:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_PROC_COUNT) proc_cnt = val[6:0];
    else mem_cnt = val[11:0];
  endtask

  // mostly full rounds of random requests, some noise
  task automatic random_rounds(int items);
    int k, r;
    k = 0;
    while (k < items) begin
      r = $urandom_range(99);
      if (r < 80) queue_beat(OP_REQ, $urandom_range(3) == 0 ? $urandom_range(2047)
                                                               : $urandom_range(15));
      else if (r < 92) queue_beat(OP_EOR, $urandom_range(2047));
      else if (r < 97) queue_beat(OP_CLR, $urandom_range(2047));
      else queue_beat(OP_NOP, $urandom_range(2047));
      k++;
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = 0; out_tready = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    fail_count = 0; cycle_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    arbiter_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every op, special cases
    queue_beat(OP_REQ, 0);
    queue_beat(OP_REQ, 0);
    queue_beat(OP_REQ, 2047);
    queue_beat(OP_REQ, 1024);
    queue_beat(OP_NOP, 2047);
    queue_beat(OP_EOR, 0);
    queue_beat(OP_REQ, 5);
    queue_beat(OP_CLR, 1365);
    queue_beat(OP_REQ, 682);
    drain();
    write_reg(CFG_PROC_COUNT, 2);
    write_reg(CFG_MEM_COUNT, 4);
    queue_beat(OP_REQ, 4);
    queue_beat(OP_REQ, 3);
    queue_beat(OP_REQ, 3);
    queue_beat(OP_REQ, 0);
    queue_beat(OP_EOR, 0);
    queue_beat(OP_REQ, 1);
    queue_beat(OP_EOR, 0);
    drain();
    write_reg(CFG_PROC_COUNT, 127);
    write_reg(CFG_MEM_COUNT, 4095);
    queue_beat(OP_REQ, 2047);
    queue_beat(OP_EOR, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      case (ph)
        0: begin write_reg(CFG_PROC_COUNT, 8); write_reg(CFG_MEM_COUNT, 16); end
        1: begin write_reg(CFG_PROC_COUNT, 1); write_reg(CFG_MEM_COUNT, 1); end
        2: begin write_reg(CFG_PROC_COUNT, 64); write_reg(CFG_MEM_COUNT, 2048); end
        3: begin write_reg(CFG_PROC_COUNT, 5); write_reg(CFG_MEM_COUNT, 9); end
        4: begin write_reg(CFG_PROC_COUNT, 100); write_reg(CFG_MEM_COUNT, 3000); end
        5: begin write_reg(CFG_PROC_COUNT, 16); write_reg(CFG_MEM_COUNT, 12); end
        6: begin write_reg(CFG_PROC_COUNT, 3); write_reg(CFG_MEM_COUNT, 2047); end
        default: begin write_reg(CFG_PROC_COUNT, 12); write_reg(CFG_MEM_COUNT, 6); end
      endcase
      random_rounds(240);
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
